FILE: rtl/core/vfj_pkg.sv
// ---------------------------------------------------------------------------
// vfj_pkg
// Shared types and constants for the vector field Jacobian stencil.
// ---------------------------------------------------------------------------
package vfj_pkg;

	// volume limits and register defaults
	localparam int DEF_MAX_SIZE_X  = 128;
	localparam int DEF_MAX_SIZE_Y  = 128;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int MIN_SIZE        = 3;
	localparam int MAX_SIZE_Z      = 4096;
	localparam int RESET_SIZE      = 128;
	localparam int ONE_Q           = 256;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int SZ_W       = 13;
	localparam int ZPOS_W     = 12;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	// per-item control that travels from the front end to the back end
	typedef struct packed {
		logic emit;      // this push also produces a result
		logic interior;  // centre voxel has all six neighbours
		logic last;      // final voxel of the volume
	} cmd_flags_t;

endpackage

FILE: rtl/core/vector_field_jacobian_stencil.sv
// ---------------------------------------------------------------------------
// vector_field_jacobian_stencil
// Streaming 3-D central-difference Jacobian of a three-component volume.
// ---------------------------------------------------------------------------
// Throughput: one beat per cycle while the queue has room; the cascade of six
// delay memories, each with one write and one read per cycle, supplies all
// neighbours each beat. A result passes the queue, a delay tap register and the
// output register after the beat that releases it; that beat comes one plane,
// one line and one voxel after the centre voxel, or is a flush beat.
// Reset: counters, queue and handshake clear at once; memories are not cleared.
module vector_field_jacobian_stencil #(
	parameter int MAX_SIZE_X  = vfj_pkg::DEF_MAX_SIZE_X,
	parameter int MAX_SIZE_Y  = vfj_pkg::DEF_MAX_SIZE_Y,
	parameter int SAMPLE_BITS = vfj_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [vfj_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [vfj_pkg::CFG_DATA_W-1:0]            cfg_data,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// comp_x, comp_y, comp_z
	input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
	// func
	input  logic                                      s_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// dvx_dx, dvx_dy, dvx_dz, dvy_dx, dvy_dy, dvy_dz, dvz_dx, dvz_dy, dvz_dz
	output logic [((9*(SAMPLE_BITS+1)+7)/8)*8-1:0]    m_tdata,
	// last_voxel
	output logic                                      m_tlast
);

	import vfj_pkg::*;

	localparam int DW  = 3 * SAMPLE_BITS;
	localparam int OW  = ((9 * (SAMPLE_BITS + 1) + 7) / 8) * 8;
	localparam int XCW = $clog2(MAX_SIZE_X + 1);
	localparam int YCW = $clog2(MAX_SIZE_Y + 1);
	localparam int FW  = $bits(cmd_flags_t);

	logic           q_wr, q_full, q_rd, q_valid;
	logic [DW-1:0]  f_data, b_data;
	cmd_flags_t     f_flags, b_flags;
	logic [XCW-1:0] size_x;
	logic [YCW-1:0] size_y;

	vfj_front #(
		.MAX_SIZE_X (MAX_SIZE_X),
		.MAX_SIZE_Y (MAX_SIZE_Y),
		.SAMPLE_BITS(SAMPLE_BITS),
		.XCW        (XCW),
		.YCW        (YCW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_tvalid),
		.in_func  (s_tuser),
		.in_data  (s_tdata[DW-1:0]),
		.in_ready (s_tready),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_data   (f_data),
		.q_flags  (f_flags),
		.size_x   (size_x),
		.size_y   (size_y)
	);

	vfj_queue #(
		.W(DW + FW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data ({f_flags, f_data}),
		.full    (q_full),
		.rd      (q_rd),
		.rd_valid(q_valid),
		.rd_data ({b_flags, b_data})
	);

	vfj_back #(
		.MAX_SIZE_X (MAX_SIZE_X),
		.MAX_SIZE_Y (MAX_SIZE_Y),
		.SAMPLE_BITS(SAMPLE_BITS),
		.XCW        (XCW),
		.YCW        (YCW),
		.OW         (OW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (cfg_we),
		.size_x  (size_x),
		.size_y  (size_y),
		.q_valid (q_valid),
		.q_data  (b_data),
		.q_flags (b_flags),
		.q_rd    (q_rd),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

FILE: rtl/core/vfj_queue.sv
// ---------------------------------------------------------------------------
// vfj_queue
// Two-entry queue between the front end and the back end.
// ---------------------------------------------------------------------------
module vfj_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd,
	output logic         rd_valid,
	output logic [W-1:0] rd_data
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/vfj_delay.sv
// ---------------------------------------------------------------------------
// vfj_delay
// Run-time length delay line in a circular memory, registered output.
// Each enabled beat adds len+1 beats of delay through the output register.
// ---------------------------------------------------------------------------
module vfj_delay #(
	parameter int DEPTH = 4,
	parameter int LW    = 8,
	parameter int W     = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          clr,
	input  logic [LW-1:0] len,
	input  logic [W-1:0]  din,
	output logic [W-1:0]  dout
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] ptr_q;
	logic [W-1:0]  dout_q;
	logic          wrap;

	assign wrap = (LW'(ptr_q) >= (len - LW'(1)));
	assign dout = dout_q;

	// read before write at the same slot
	always_ff @(posedge clk) begin
		if (en) begin
			dout_q   <= mem[ptr_q];
			mem[ptr_q] <= din;
		end
	end

	// slot pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (clr) begin
			ptr_q <= '0;
		end else if (en) begin
			ptr_q <= wrap ? '0 : ptr_q + AW'(1);
		end
	end

endmodule

FILE: rtl/core/vfj_front.sv
// ---------------------------------------------------------------------------
// vfj_front
// Front end: size registers, input and output raster positions, and the
// classification of each beat into push / emit commands for the back end.
// ---------------------------------------------------------------------------
module vfj_front #(
	parameter int MAX_SIZE_X  = 128,
	parameter int MAX_SIZE_Y  = 128,
	parameter int SAMPLE_BITS = 16,
	parameter int XCW         = 8,
	parameter int YCW         = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vfj_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vfj_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	input  logic                            in_func,
	input  logic [3*SAMPLE_BITS-1:0]        in_data,
	output logic                            in_ready,
	input  logic                            q_full,
	output logic                            q_wr,
	output logic [3*SAMPLE_BITS-1:0]        q_data,
	output vfj_pkg::cmd_flags_t             q_flags,
	output logic [XCW-1:0]                  size_x,
	output logic [YCW-1:0]                  size_y
);

	import vfj_pkg::*;

	localparam int XW = $clog2(MAX_SIZE_X);
	localparam int YW = $clog2(MAX_SIZE_Y);

	logic [XCW-1:0]    sx_q;
	logic [YCW-1:0]    sy_q;
	logic [SZ_W-1:0]   sz_q;
	logic [XW-1:0]     in_x_q, out_x_q;
	logic [YW-1:0]     in_y_q, out_y_q;
	logic [ZPOS_W-1:0] in_z_q, out_z_q;
	logic              rx_done_q;
	logic              accept, is_data, push, emit, warm;
	logic              in_end_x, in_end_y, in_end_z;
	logic              out_end_x, out_end_y, out_end_z, out_last, interior;
	logic              cfg_hit;

	assign size_x   = sx_q;
	assign size_y   = sy_q;
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_data  = !in_func;
	assign cfg_hit  = cfg_we && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
		cfg_index == REG_SIZE_Z);

	// input is at least one plane, one line and one voxel ahead of the output
	assign warm = (in_z_q > ZPOS_W'(1)) ||
		((in_z_q == ZPOS_W'(1)) && ((in_y_q > YW'(1)) ||
		((in_y_q == YW'(1)) && (in_x_q >= XW'(1)))));

	assign in_end_x = (XCW'(in_x_q) == sx_q - XCW'(1));
	assign in_end_y = (YCW'(in_y_q) == sy_q - YCW'(1));
	assign in_end_z = (SZ_W'(in_z_q) == sz_q - SZ_W'(1));

	assign out_end_x = (XCW'(out_x_q) == sx_q - XCW'(1));
	assign out_end_y = (YCW'(out_y_q) == sy_q - YCW'(1));
	assign out_end_z = (SZ_W'(out_z_q) == sz_q - SZ_W'(1));
	assign out_last  = out_end_x && out_end_y && out_end_z;

	// face voxels take the identity matrix
	assign interior = (out_x_q != '0) && ((XCW+1)'(out_x_q) + (XCW+1)'(2) <= (XCW+1)'(sx_q)) &&
		(out_y_q != '0) && ((YCW+1)'(out_y_q) + (YCW+1)'(2) <= (YCW+1)'(sy_q)) &&
		(out_z_q != '0) && ((SZ_W+1)'(out_z_q) + (SZ_W+1)'(2) <= (SZ_W+1)'(sz_q));

	// classify the beat: real push, dummy push while draining, or nothing
	always_comb begin
		push = 1'b0;
		emit = 1'b0;
		if (accept) begin
			if (is_data && !rx_done_q) begin
				push = 1'b1;
				emit = warm;
			end else if (rx_done_q) begin
				push = 1'b1;
				emit = 1'b1;
			end
		end
	end

	assign q_wr             = push;
	assign q_data           = (is_data && !rx_done_q) ? in_data : '0;
	assign q_flags.emit     = emit;
	assign q_flags.interior = interior;
	assign q_flags.last     = out_last;

	// size registers, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= XCW'((RESET_SIZE > MAX_SIZE_X) ? MAX_SIZE_X : RESET_SIZE);
			sy_q <= YCW'((RESET_SIZE > MAX_SIZE_Y) ? MAX_SIZE_Y : RESET_SIZE);
			sz_q <= SZ_W'(RESET_SIZE);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE_X: begin
					if (int'(cfg_data[7:0]) < MIN_SIZE) sx_q <= XCW'(MIN_SIZE);
					else if (int'(cfg_data[7:0]) > MAX_SIZE_X) sx_q <= XCW'(MAX_SIZE_X);
					else sx_q <= XCW'(cfg_data[7:0]);
				end
				REG_SIZE_Y: begin
					if (int'(cfg_data[7:0]) < MIN_SIZE) sy_q <= YCW'(MIN_SIZE);
					else if (int'(cfg_data[7:0]) > MAX_SIZE_Y) sy_q <= YCW'(MAX_SIZE_Y);
					else sy_q <= YCW'(cfg_data[7:0]);
				end
				REG_SIZE_Z: begin
					if (int'(cfg_data) < MIN_SIZE) sz_q <= SZ_W'(MIN_SIZE);
					else if (int'(cfg_data) > MAX_SIZE_Z) sz_q <= SZ_W'(MAX_SIZE_Z);
					else sz_q <= SZ_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// raster positions on both sides; restart on a size register write or after the last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_x_q    <= '0;
			in_y_q    <= '0;
			in_z_q    <= '0;
			out_x_q   <= '0;
			out_y_q   <= '0;
			out_z_q   <= '0;
			rx_done_q <= 1'b0;
		end else if (cfg_hit || (emit && out_last)) begin
			in_x_q    <= '0;
			in_y_q    <= '0;
			in_z_q    <= '0;
			out_x_q   <= '0;
			out_y_q   <= '0;
			out_z_q   <= '0;
			rx_done_q <= 1'b0;
		end else begin
			if (accept && is_data && !rx_done_q) begin
				if (in_end_x) begin
					in_x_q <= '0;
					if (in_end_y) begin
						in_y_q <= '0;
						if (in_end_z) rx_done_q <= 1'b1;
						else in_z_q <= in_z_q + ZPOS_W'(1);
					end else begin
						in_y_q <= in_y_q + YW'(1);
					end
				end else begin
					in_x_q <= in_x_q + XW'(1);
				end
			end
			if (emit) begin
				if (out_end_x) begin
					out_x_q <= '0;
					if (out_end_y) begin
						out_y_q <= '0;
						out_z_q <= out_z_q + ZPOS_W'(1);
					end else begin
						out_y_q <= out_y_q + YW'(1);
					end
				end else begin
					out_x_q <= out_x_q + XW'(1);
				end
			end
		end
	end

endmodule

FILE: rtl/core/vfj_back.sv
// ---------------------------------------------------------------------------
// vfj_back
// Back end: cascade of plane and line delay lines giving the six neighbour
// taps, difference stage and output register.
// ---------------------------------------------------------------------------
module vfj_back #(
	parameter int MAX_SIZE_X  = 128,
	parameter int MAX_SIZE_Y  = 128,
	parameter int SAMPLE_BITS = 16,
	parameter int XCW         = 8,
	parameter int YCW         = 8,
	parameter int OW          = 160
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clr,
	input  logic [XCW-1:0]           size_x,
	input  logic [YCW-1:0]           size_y,
	input  logic                     q_valid,
	input  logic [3*SAMPLE_BITS-1:0] q_data,
	input  vfj_pkg::cmd_flags_t      q_flags,
	output logic                     q_rd,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OW-1:0]            m_tdata,
	output logic                     m_tlast
);

	import vfj_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int DW = 3 * SB;
	localparam int RW = SB + 1;
	localparam int LW = $clog2(MAX_SIZE_X * MAX_SIZE_Y + 1);

	logic [LW-1:0] plane, sxl;
	logic [LW-1:0] len [6];
	logic [DW-1:0] tap [6];
	logic [DW-1:0] chain_in [6];
	logic [RW-1:0] res [9];
	cmd_flags_t    flags_s1;
	logic          valid_s1;
	logic          out_free, adv_s1;
	logic [RW-1:0] res_q [9];
	logic          last_q, out_valid_q;

	// line and plane lengths
	assign sxl   = LW'(size_x);
	assign plane = LW'(size_x) * LW'(size_y);
	assign len[0] = sxl + LW'(1);
	assign len[1] = plane - sxl - LW'(1);
	assign len[2] = sxl - LW'(2);
	assign len[3] = LW'(1);
	assign len[4] = sxl - LW'(2);
	assign len[5] = plane - sxl - LW'(1);

	// handshake between queue, stage 1 and the output register
	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!flags_s1.emit || out_free);
	assign q_rd     = q_valid && (!valid_s1 || adv_s1);

	// delay cascade: taps hold e+plane, e+sx, e+1, e-1, e-sx, e-plane
	assign chain_in[0] = q_data;
	for (genvar k = 1; k < 6; k++) begin : g_link
		assign chain_in[k] = tap[k-1];
	end

	for (genvar k = 0; k < 6; k++) begin : g_dly
		localparam int DEP = (k == 3) ? 1 :
			((k == 1 || k == 5) ? MAX_SIZE_X * MAX_SIZE_Y :
			((k == 0) ? MAX_SIZE_X + 1 : MAX_SIZE_X));
		vfj_delay #(
			.DEPTH(DEP),
			.LW   (LW),
			.W    (DW)
		) u_dly (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (q_rd),
			.clr   (clr),
			.len   (len[k]),
			.din   (chain_in[k]),
			.dout  (tap[k])
		);
	end

	// central differences, identity on faces
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (flags_s1.interior) begin
				res[c*3+0] = RW'($signed(tap[2][c*SB +: SB])) - RW'($signed(tap[3][c*SB +: SB]));
				res[c*3+1] = RW'($signed(tap[1][c*SB +: SB])) - RW'($signed(tap[4][c*SB +: SB]));
				res[c*3+2] = RW'($signed(tap[0][c*SB +: SB])) - RW'($signed(tap[5][c*SB +: SB]));
			end else begin
				for (int d = 0; d < 3; d++) begin
					res[c*3+d] = (c == d) ? RW'(ONE_Q) : '0;
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flags_s1 <= '0;
		end else if (q_rd) begin
			valid_s1 <= 1'b1;
			flags_s1 <= q_flags;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && flags_s1.emit) begin
			res_q  <= res;
			last_q <= flags_s1.last;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && flags_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < 9; i++) begin
			m_tdata[i*RW +: RW] = res_q[i];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = last_q;

endmodule
